@@ rtl/column_span_occlusion_trim_core_assert.svh @@
// Assertion macros for the column span trim core.
`ifndef COLUMN_SPAN_OCCLUSION_TRIM_CORE_ASSERT_SVH
`define COLUMN_SPAN_OCCLUSION_TRIM_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset.
`define CSOT_ASSERT(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
// Check an implication of the next cycle outside reset.
`define CSOT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CSOT_ASSERT(label, cond, msg)
`define CSOT_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

@@ rtl/csot_pkg.sv @@
package csot_pkg;

	localparam int COLUMN_HEIGHT_DEF = 128;
	localparam int ROW_W = 7;
	localparam int SPAN_W = 13;
	localparam int OP_W = 2;

	localparam logic [OP_W-1:0] OP_CLEAR = 2'd0;
	localparam logic [OP_W-1:0] OP_WALL = 2'd1;
	localparam logic [OP_W-1:0] OP_FLOOR = 2'd2;

	// Control of the coverage ring, broadcast to every cell.
	typedef struct packed {
		logic shift;
		logic clear;
		logic tail;
	} ring_ctl_t;

endpackage

@@ rtl/csot_cell.sv @@
module csot_cell import csot_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  ring_ctl_t ctl,
	input  logic      nxt,
	output logic      cov
);

	logic cov_q;

	// Drop the bit on clear, otherwise take the neighbor's bit on shift.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cov_q <= 1'b0;
		end else if (ctl.clear) begin
			cov_q <= 1'b0;
		end else if (ctl.shift) begin
			cov_q <= nxt;
		end
	end

	assign cov = cov_q;

endmodule

@@ rtl/csot_ring.sv @@
module csot_ring import csot_pkg::*; #(
	parameter int COLUMN_HEIGHT = COLUMN_HEIGHT_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  ring_ctl_t ctl,
	output logic      head
);

	logic [COLUMN_HEIGHT-1:0] cov;
	logic [COLUMN_HEIGHT-1:0] nxt;

	genvar i;
	generate
		for (i = 0; i < COLUMN_HEIGHT; i++) begin : g_cell
			if (i == COLUMN_HEIGHT - 1) begin : g_tail
				assign nxt[i] = ctl.tail;
			end else begin : g_mid
				assign nxt[i] = cov[i+1];
			end
			csot_cell u_cell (
				.clk    (clk),
				.arst_n (arst_n),
				.ctl    (ctl),
				.nxt    (nxt[i]),
				.cov    (cov[i])
			);
		end
	endgenerate

	assign head = cov[0];

endmodule

@@ rtl/column_span_occlusion_trim_core.sv @@
// Column span trim core: one-bit coverage map of a screen column.
// Request channel (req_valid / req_stall): operation, span_a, span_b. A request
// is taken at a clock edge with req_valid high and req_stall low.
// Result channel (res_valid / res_stall): seg_start, seg_end, seg_valid, last.
// Each request gives one or more results; last marks the final one, and a
// request with nothing to draw gives a single result with seg_valid low.
// The map lives in a ring of COLUMN_HEIGHT cells that rotates one row per
// cycle past a head cell while a span is scanned and no result stall holds
// it. A span request takes up to two full turns of the ring: one to trim
// both ends, one to mark rows and find segments. One request is in work at
// a time; req_stall stays high until its final result is in the output
// register. A stall on the result side holds the ring wherever a segment
// must leave, so no result is lost. Reset empties the map at once and drops
// all work.
`include "column_span_occlusion_trim_core_assert.svh"

module column_span_occlusion_trim_core import csot_pkg::*; #(
	parameter int COLUMN_HEIGHT = COLUMN_HEIGHT_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     req_valid,
	output logic                     req_stall,
	input  logic [OP_W-1:0]          operation,
	input  logic signed [SPAN_W-1:0] span_a,
	input  logic signed [SPAN_W-1:0] span_b,
	output logic                     res_valid,
	input  logic                     res_stall,
	output logic [ROW_W-1:0]         seg_start,
	output logic [ROW_W-1:0]         seg_end,
	output logic                     seg_valid,
	output logic                     last
);

	localparam int RW = $clog2(COLUMN_HEIGHT);
	localparam logic [RW-1:0] CNT_LAST = RW'(COLUMN_HEIGHT - 1);
	localparam logic signed [SPAN_W-1:0] ROW_MAX = SPAN_W'(COLUMN_HEIGHT - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_SCAN1,
		ST_CHECK,
		ST_SCAN2,
		ST_FLUSH
	} state_t;

	state_t                   state_q;
	logic [OP_W-1:0]          op_q;
	logic signed [SPAN_W-1:0] a_q, b_q;
	logic [ROW_W-1:0]         s_q, e_q, f_q, l_q, run_start_q;
	logic                     f_found_q, l_found_q, in_run_q;
	logic [RW-1:0]            cnt_q;
	logic                     pend_v_q;
	logic [ROW_W-1:0]         pend_s_q, pend_e_q;
	logic                     res_valid_q, seg_valid_q, last_q;
	logic [ROW_W-1:0]         seg_start_q, seg_end_q;

	ring_ctl_t ctl;
	logic      head;

	logic                     req_take;
	logic signed [SPAN_W-1:0] lo_w, hi_w;
	logic [ROW_W-1:0]         lo_c, hi_c, row;
	logic                     prep_ok, check_ok;
	logic                     is_floor, in_win1, in_win2, skip, mark;
	logic                     emit;
	logic [ROW_W-1:0]         emit_s, emit_e;
	logic                     out_free, adv;
	logic                     res_load;

	csot_ring #(
		.COLUMN_HEIGHT (COLUMN_HEIGHT)
	) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.head   (head)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign req_take  = req_valid && !req_stall;
	assign row       = ROW_W'(cnt_q);
	assign out_free  = !res_valid_q || !res_stall;

	// Order both ends, then clamp them to the column.
	always_comb begin
		lo_w = (a_q > b_q) ? b_q : a_q;
		hi_w = (a_q > b_q) ? a_q : b_q;
		if (lo_w < 0) begin
			lo_c = '0;
		end else if (lo_w > ROW_MAX) begin
			lo_c = ROW_MAX[ROW_W-1:0];
		end else begin
			lo_c = lo_w[ROW_W-1:0];
		end
		if (hi_w < 0) begin
			hi_c = '0;
		end else if (hi_w > ROW_MAX) begin
			hi_c = ROW_MAX[ROW_W-1:0];
		end else begin
			hi_c = hi_w[ROW_W-1:0];
		end
		prep_ok = (a_q != b_q) && (lo_c != hi_c);
	end

	// Trimmed range is valid when an open row lies below the end row and
	// a later open row exists to serve as the new end.
	assign check_ok = f_found_q && l_found_q && (l_q > f_q);

	assign is_floor = (op_q == OP_FLOOR);
	assign in_win1  = (row >= s_q) && (row <= e_q);
	assign in_win2  = (row >= f_q) && (row <= l_q);
	// A floor walk that reaches the end row over covered rows stops there:
	// that lone end row is neither marked nor emitted.
	assign skip     = is_floor && (row == l_q) && !in_run_q && !head;
	assign mark     = in_win2 && (!is_floor || (!head && !skip));

	always_comb begin
		emit   = 1'b0;
		emit_s = run_start_q;
		emit_e = row;
		if (state_q == ST_SCAN2 && is_floor && in_win2) begin
			if (!head && !skip && row == l_q) begin
				emit   = 1'b1;
				emit_s = in_run_q ? run_start_q : row;
				emit_e = row;
			end else if (head && in_run_q) begin
				emit   = 1'b1;
				emit_s = run_start_q;
				emit_e = row - 1'b1;
			end
		end
	end

	// Hold the ring while a pending segment cannot move to the output.
	assign adv = !emit || !pend_v_q || out_free;

	// Load the output register with an older segment or with the final result.
	assign res_load = (state_q == ST_SCAN2 && adv && emit && pend_v_q) ||
		(state_q == ST_FLUSH && out_free);

	always_comb begin
		ctl.clear = req_take && (operation == OP_CLEAR);
		ctl.shift = (state_q == ST_SCAN1) || (state_q == ST_SCAN2 && adv);
		ctl.tail  = (state_q == ST_SCAN2 && mark) ? 1'b1 : head;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_CLEAR;
			a_q         <= '0;
			b_q         <= '0;
			s_q         <= '0;
			e_q         <= '0;
			f_q         <= '0;
			l_q         <= '0;
			run_start_q <= '0;
			f_found_q   <= 1'b0;
			l_found_q   <= 1'b0;
			in_run_q    <= 1'b0;
			cnt_q       <= '0;
			pend_v_q    <= 1'b0;
			pend_s_q    <= '0;
			pend_e_q    <= '0;
			res_valid_q <= 1'b0;
			seg_valid_q <= 1'b0;
			last_q      <= 1'b0;
			seg_start_q <= '0;
			seg_end_q   <= '0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_take) begin
						op_q     <= operation;
						a_q      <= span_a;
						b_q      <= span_b;
						cnt_q    <= '0;
						pend_v_q <= 1'b0;
						if (operation inside {OP_WALL, OP_FLOOR}) begin
							state_q <= ST_PREP;
						end else begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_PREP: begin
					s_q       <= lo_c;
					e_q       <= hi_c;
					f_found_q <= 1'b0;
					l_found_q <= 1'b0;
					state_q   <= prep_ok ? ST_SCAN1 : ST_FLUSH;
				end
				ST_SCAN1: begin
					if (in_win1 && !head) begin
						if (row < e_q && !f_found_q) begin
							f_q       <= row;
							f_found_q <= 1'b1;
						end
						l_q       <= row;
						l_found_q <= 1'b1;
					end
					if (cnt_q == CNT_LAST) begin
						cnt_q   <= '0;
						state_q <= ST_CHECK;
					end else begin
						cnt_q <= cnt_q + 1'b1;
					end
				end
				ST_CHECK: begin
					in_run_q <= 1'b0;
					if (!check_ok) begin
						state_q <= ST_FLUSH;
					end else begin
						state_q <= ST_SCAN2;
						if (!is_floor) begin
							pend_v_q <= 1'b1;
							pend_s_q <= f_q;
							pend_e_q <= l_q;
						end
					end
				end
				ST_SCAN2: begin
					if (adv) begin
						if (is_floor && in_win2) begin
							if (!head && !skip) begin
								if (!in_run_q) begin
									run_start_q <= row;
								end
								in_run_q <= (row != l_q);
							end else if (head) begin
								in_run_q <= 1'b0;
							end
						end
						if (emit) begin
							// Release the older segment; it is not the final one.
							if (pend_v_q) begin
								seg_valid_q <= 1'b1;
								last_q      <= 1'b0;
								seg_start_q <= pend_s_q;
								seg_end_q   <= pend_e_q;
							end
							pend_v_q <= 1'b1;
							pend_s_q <= emit_s;
							pend_e_q <= emit_e;
						end
						if (cnt_q == CNT_LAST) begin
							cnt_q   <= '0;
							state_q <= ST_FLUSH;
						end else begin
							cnt_q <= cnt_q + 1'b1;
						end
					end
				end
				ST_FLUSH: begin
					if (out_free) begin
						last_q      <= 1'b1;
						seg_valid_q <= pend_v_q;
						seg_start_q <= pend_v_q ? pend_s_q : '0;
						seg_end_q   <= pend_v_q ? pend_e_q : '0;
						pend_v_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign res_valid = res_valid_q;
	assign seg_start = seg_start_q;
	assign seg_end   = seg_end_q;
	assign seg_valid = seg_valid_q;
	assign last      = last_q;

	`CSOT_ASSERT(a_seg_order, !(res_valid && seg_valid) || (seg_start <= seg_end), "segment start after end")
	`CSOT_ASSERT(a_empty_form, !(res_valid && !seg_valid) || (last && seg_start == '0 && seg_end == '0), "malformed empty result")
	`CSOT_ASSERT(a_ring_aligned, (state_q != ST_IDLE) || (cnt_q == '0), "ring not aligned at idle")
	`CSOT_ASSERT_NEXT(a_one_in_work, req_valid && !req_stall, req_stall, "second request taken while busy")

endmodule

@@ test/tb.sv @@
module tb;
	import csot_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROWS = COLUMN_HEIGHT_DEF;
	localparam int CLK_PERIOD = 10;
	localparam int RESET_CYCLES = 7;
	// A span takes about two turns of the ring; allow for the tail after the last result.
	localparam int SPAN_CYCLES = 2 * ROWS + 8;
	// Worst case is roughly 480 requests, each with a span walk, up to 64 stalled results and a sender gap.
	// Take that several times over.
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int RANDOM_REQUESTS = 410;
	localparam int MAX_SEGS = 64;
	localparam int PRINT_CAP = 40;

	// Selector code with no function in the block.
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

	// One result as it leaves the block.
	typedef struct packed {
		logic [ROW_W-1:0] first_row;
		logic [ROW_W-1:0] last_row;
		logic             drawn;
		logic             final_res;
	} seg_res_t;

	logic                     clk = 1'b0;
	logic                     arst_n;
	logic                     req_valid;
	logic                     req_stall;
	logic [OP_W-1:0]          operation;
	logic signed [SPAN_W-1:0] span_a;
	logic signed [SPAN_W-1:0] span_b;
	logic                     res_valid;
	logic                     res_stall = 1'b0;
	logic [ROW_W-1:0]         seg_start;
	logic [ROW_W-1:0]         seg_end;
	logic                     seg_valid;
	logic                     last;

	// Predicted coverage of the column, one bit per row, 1 = covered.
	logic [ROWS-1:0] coverage_bits = '0;
	// Segments still owed by the block, oldest first.
	seg_res_t        segs_due[$];

	int errors = 0;
	int cycle_count = 0;
	int requests_sent = 0;
	int results_checked = 0;
	int segments_seen = 0;
	int empties_seen = 0;
	int longest_floor = 0;
	int burst_left = 0;
	bit pace_on = 1'b1;
	int stall_tick = 0;
	int stall_run = 0;
	seg_res_t want_seg;
	seg_res_t got_seg;

	column_span_occlusion_trim_core #(
		.COLUMN_HEIGHT(ROWS)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.operation (operation),
		.span_a    (span_a),
		.span_b    (span_b),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.seg_start (seg_start),
		.seg_end   (seg_end),
		.seg_valid (seg_valid),
		.last      (last)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Watchdog: a hung block or a lost result ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: timeout, %0d results still owed", $time, segs_due.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Rows outside the column never count as covered.
	function automatic bit row_covered(input int row);
		if (row < 0 || row >= ROWS)
			return 1'b0;
		return coverage_bits[row];
	endfunction

	function automatic int clamp_to_column(input int row);
		if (row < 0)
			return 0;
		if (row >= ROWS)
			return ROWS - 1;
		return row;
	endfunction

	// Order the ends, clamp them to the column and shave covered rows off both sides.
	// Return 0 when nothing is left to draw.
	function automatic bit trim_ends(input int a, input int b, output int s, output int e);
		int t;
		s = a;
		e = b;
		if (s > e) begin
			t = s;
			s = e;
			e = t;
		end
		if (s == e)
			return 1'b0;
		s = clamp_to_column(s);
		e = clamp_to_column(e);
		if (s == e)
			return 1'b0;
		while (s < e && row_covered(s))
			s++;
		if (s == e)
			return 1'b0;
		while (e > s && row_covered(e))
			e--;
		return s != e;
	endfunction

	// Apply one request to the predicted map and queue the segments it must produce.
	function automatic void trim_and_paint(input logic [OP_W-1:0] op,
			input logic signed [SPAN_W-1:0] a, input logic signed [SPAN_W-1:0] b);
		int s;
		int e;
		int cs;
		int ce;
		int n;
		int i;
		int firsts[MAX_SEGS];
		int lasts[MAX_SEGS];
		seg_res_t r;
		n = 0;
		if (op == OP_CLEAR) begin
			coverage_bits = '0;
		end else if (op == OP_WALL) begin
			if (trim_ends(int'(a), int'(b), s, e)) begin
				// Wall: the whole trimmed range is one segment, covered interior included.
				for (i = s; i <= e; i++)
					coverage_bits[i] = 1'b1;
				firsts[0] = s;
				lasts[0] = e;
				n = 1;
			end
		end else if (op == OP_FLOOR) begin
			if (trim_ends(int'(a), int'(b), s, e)) begin
				cs = s;
				while (cs < e && n < MAX_SEGS) begin
					while (cs <= e && row_covered(cs))
						cs++;
					// Landing on the end row after a covered run stops the walk;
					// the end row stays open.
					if (cs == e)
						break;
					ce = cs;
					while (ce <= e && !row_covered(ce)) begin
						coverage_bits[ce] = 1'b1;
						ce++;
					end
					firsts[n] = cs;
					lasts[n] = ce - 1;
					n++;
					cs = ce;
				end
				if (n > longest_floor)
					longest_floor = n;
			end
		end
		if (n == 0) begin
			r = '{first_row: '0, last_row: '0, drawn: 1'b0, final_res: 1'b1};
			segs_due = {segs_due, r};
		end else begin
			for (i = 0; i < n; i++) begin
				r.first_row = ROW_W'(firsts[i]);
				r.last_row = ROW_W'(lasts[i]);
				r.drawn = 1'b1;
				r.final_res = (i == n - 1);
				segs_due = {segs_due, r};
			end
		end
	endfunction

	// Send one request, honoring the burst/gap pacing, and predict its results once taken.
	task automatic send_request(input logic [OP_W-1:0] op, input int a, input int b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = pace_on ? $urandom_range(1, 7) : 0;
			if (gap > 0) begin
				@(negedge clk);
				req_valid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		req_valid <= 1'b1;
		operation <= op;
		span_a <= SPAN_W'(a);
		span_b <= SPAN_W'(b);
		// Hold the request until a rising edge sees it with no stall.
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		trim_and_paint(op, SPAN_W'(a), SPAN_W'(b));
		requests_sent++;
	endtask

	// Idle the request side until every owed result has come back.
	task automatic settle_results();
		@(negedge clk);
		req_valid <= 1'b0;
		while (segs_due.size() != 0)
			@(posedge clk);
	endtask

	// Pick an end row: mostly near the column, sometimes anywhere in the 13-bit range.
	function automatic logic signed [SPAN_W-1:0] pick_row();
		case ($urandom_range(0, 9))
			0, 1: return SPAN_W'($urandom);
			2: return SPAN_W'(int'($urandom_range(0, 12)) - 6);
			default: return SPAN_W'(int'($urandom_range(0, ROWS + 11)) - 6);
		endcase
	endfunction

	// Extremes, every operation, and each corner of the trim and walk logic.
	task automatic test_directed();
		send_request(OP_CLEAR, 0, 0);
		send_request(OP_WALL, -4096, 4095);      // full column, both ends off screen
		send_request(OP_FLOOR, 4095, -4096);     // every row covered: nothing drawn
		send_request(OP_UNUSED, -1, 77);         // map untouched, empty result
		send_request(OP_CLEAR, 4095, -4096);
		send_request(OP_WALL, 33, 33);           // equal ends
		send_request(OP_WALL, -50, -2);          // equal after clamping low
		send_request(OP_FLOOR, 300, 4000);       // equal after clamping high
		send_request(OP_FLOOR, 4095, -4096);     // one open run over the whole column
		send_request(OP_CLEAR, -4096, -4096);
		send_request(OP_WALL, 30, 20);           // swapped ends
		send_request(OP_FLOOR, 10, 31);          // scan lands on end row: row 31 stays open
		send_request(OP_FLOOR, 31, 32);          // proves row 31 was left unpainted
		send_request(OP_WALL, 60, 70);
		send_request(OP_WALL, 80, 50);           // covered interior inside a wall
		send_request(OP_WALL, 55, 75);           // trimmed ends meet
		send_request(OP_UNUSED, 4095, -4096);
		send_request(OP_FLOOR, -4096, 4095);     // three open runs between walls
		send_request(OP_CLEAR, 0, 0);
		send_request(OP_FLOOR, 127, 126);        // top two rows
		send_request(OP_FLOOR, 0, 1);            // bottom two rows
		send_request(OP_WALL, -1, 0);            // both clamp to row 0
		send_request(OP_WALL, 127, 128);         // both clamp to the top row
		send_request(OP_FLOOR, 2047, -2048);
	endtask

	// Comb the column so that one floor span splits into dozens of segments.
	task automatic test_many_segments();
		int k;
		send_request(OP_CLEAR, 0, 0);
		for (k = 0; 3 * k + 2 < ROWS; k++)
			send_request(OP_WALL, 3 * k + 1, 3 * k + 2);
		send_request(OP_FLOOR, 0, ROWS - 1);
		send_request(OP_FLOOR, ROWS - 1, 0);
	endtask

	// Random mix: mostly wall and floor spans, short and long, with rare clears.
	task automatic test_random_spans(input int count);
		int i;
		int pick;
		logic [OP_W-1:0] op;
		logic signed [SPAN_W-1:0] a;
		logic signed [SPAN_W-1:0] b;
		for (i = 0; i < count; i++) begin
			// Alternate paced and back-to-back stretches.
			if (i % 50 == 0)
				pace_on = (i % 100 == 0);
			// Drop the sender once mid-run until the block has drained.
			if (i == count / 2)
				settle_results();
			pick = $urandom_range(0, 99);
			if (pick < 5)
				op = OP_CLEAR;
			else if (pick < 8)
				op = OP_UNUSED;
			else if (pick < 50)
				op = OP_WALL;
			else
				op = OP_FLOOR;
			a = pick_row();
			if ($urandom_range(0, 3) == 0)
				b = pick_row();
			else
				b = a + SPAN_W'(int'($urandom_range(0, 24)) - 12);
			send_request(op, int'(a), int'(b));
		end
		pace_on = 1'b1;
	endtask

	// Result side stalls in rotating modes: none, coin flip, fixed pattern, long bursts.
	always @(negedge clk) begin
		stall_tick++;
		case ((stall_tick / 1200) % 4)
			0: res_stall <= 1'b0;
			1: res_stall <= 1'($urandom_range(0, 1));
			2: res_stall <= (stall_tick % 5) < 2;
			default: begin
				if (stall_run > 0) begin
					stall_run--;
					res_stall <= 1'b1;
				end else if ($urandom_range(0, 5) == 0) begin
					stall_run = $urandom_range(1, 7);
					res_stall <= 1'b1;
				end else begin
					res_stall <= 1'b0;
				end
			end
		endcase
	end

	// Compare each accepted result with the oldest owed segment.
	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			got_seg = {seg_start, seg_end, seg_valid, last};
			results_checked++;
			if (seg_valid)
				segments_seen++;
			else
				empties_seen++;
			if (segs_due.size() == 0) begin
				errors++;
				if (errors <= PRINT_CAP)
					$display("%0t: unexpected result start %0d end %0d valid %0b last %0b",
						$time, seg_start, seg_end, seg_valid, last);
			end else begin
				want_seg = segs_due.pop_front();
				if (want_seg != got_seg) begin
					errors++;
					if (errors <= PRINT_CAP)
						$display({"%0t: mismatch: expected start %0d end %0d valid %0b last %0b,",
							" got start %0d end %0d valid %0b last %0b"}, $time,
							want_seg.first_row, want_seg.last_row, want_seg.drawn,
							want_seg.final_res, seg_start, seg_end, seg_valid, last);
				end
			end
		end
	end

	initial begin
		// Drive every input to a known value and hold reset.
		arst_n = 1'b0;
		req_valid = 1'b0;
		operation = OP_CLEAR;
		span_a = '0;
		span_b = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		settle_results();
		test_many_segments();
		test_random_spans(RANDOM_REQUESTS);

		// Drain, then give the ring time to show any stray result.
		settle_results();
		repeat (SPAN_CYCLES) @(posedge clk);

		$display("Run covered %0d requests of every kind, %0d results checked (%0d segments, %0d empty).",
			requests_sent, results_checked, segments_seen, empties_seen);
		$display("Longest floor walk gave %0d segments; %0d mismatches.", longest_floor, errors);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/csot_pkg.sv
rtl/csot_cell.sv
rtl/csot_ring.sv
rtl/column_span_occlusion_trim_core.sv
test/tb.sv
